// ===== design/lfcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser package
// Shared widths, frame constants and status codes for the measurement
// frame checksum parser.
// ----------------------------------------------------------------------------
package lfcp_pkg;

  localparam int unsigned FrameLen    = 9;
  localparam int unsigned PosWidth    = 4;
  localparam int unsigned PayloadLen  = 6;
  localparam int unsigned PayloadIdxW = 3;
  localparam int unsigned TempWidth   = 17;

  localparam logic [7:0]            SyncByte   = 8'h59;
  localparam logic [PosWidth-1:0]   LastPos    = PosWidth'(FrameLen - 1);
  localparam logic [TempWidth-1:0]  TempOffset = TempWidth'(2048);

  typedef enum logic [1:0] {
    STATUS_GOOD       = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_BAD_SUM    = 2'd2
  } frame_status_t;

endpackage
`default_nettype wire

// ===== design/lidar_frame_checksum_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Measurement frame checksum parser
// Parses fixed nine-byte sensor frames with an 8-bit additive checksum and
// reports the latest good distance, amplitude, temperature and timestamp.
// ----------------------------------------------------------------------------
// The parser takes one received byte per word on the rx channel, together
// with the current millisecond tick. Frames are nine bytes long and stay
// aligned from reset; there is no hunting for the sync bytes. Each byte
// passes through an input register and is then folded into a running 8-bit
// sum, the header check and a six-byte payload store, so the block
// sustains one byte per clock. On the ninth byte it emits one word on
// the frame channel: a status (good, bad header or checksum mismatch) and
// the latest good measurement. The measurement fields are updated only by a
// good frame, and read as zero until the first one arrives. A result waits
// in the output register while further bytes of the next frame keep being
// taken; only the ninth byte of a frame stalls, and only while the previous
// result has not yet been taken.
module lidar_frame_checksum_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // Byte input channel.
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [31:0] now_ms,
  // Result channel.
  output logic             frame_valid,
  input  wire logic        frame_ready,
  output logic [1:0]       frame_status,
  output logic [15:0]      distance,
  output logic [15:0]      amplitude,
  output logic signed [lfcp_pkg::TempWidth-1:0] temperature_eighths,
  output logic [31:0]      stamp_ms
);

  // Input register.
  logic        in_vld;
  logic [7:0]  in_byte;
  logic [31:0] in_now;

  // Frame state.
  logic [lfcp_pkg::PosWidth-1:0] byte_position;
  logic [7:0]                    running_sum;
  logic                          header_good;
  logic [7:0]                    payload_bytes [lfcp_pkg::PayloadLen];

  // Latest good measurement.
  logic [15:0]                    latest_distance;
  logic [15:0]                    latest_amplitude;
  logic [lfcp_pkg::TempWidth-1:0] latest_temperature;
  logic [31:0]                    latest_stamp;

  // Result register.
  logic                    res_vld;
  lfcp_pkg::frame_status_t res_status;

  logic                          is_last;
  logic                          advance;
  logic                          slot_free;
  lfcp_pkg::frame_status_t       status_next;
  logic [15:0]                   raw_temp;
  logic [lfcp_pkg::PosWidth-1:0] store_off;
  logic [lfcp_pkg::PayloadIdxW-1:0] store_idx;

  // Any position at or beyond the last one is treated as the final byte.
  assign is_last   = (byte_position >= lfcp_pkg::LastPos);
  assign slot_free = !res_vld || frame_ready;
  // The byte in the input register moves on unless it closes a frame and
  // the previous result still occupies the output register.
  assign advance   = in_vld && (!is_last || slot_free);
  assign rx_ready  = !in_vld || advance;

  assign store_off = byte_position - lfcp_pkg::PosWidth'(2);
  assign store_idx = store_off[lfcp_pkg::PayloadIdxW-1:0];
  assign raw_temp  = {payload_bytes[5], payload_bytes[4]};

  always_comb begin
    if (!header_good) begin
      status_next = lfcp_pkg::STATUS_BAD_HEADER;
    end else if (running_sum != in_byte) begin
      status_next = lfcp_pkg::STATUS_BAD_SUM;
    end else begin
      status_next = lfcp_pkg::STATUS_GOOD;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (rx_ready) begin
      in_vld <= rx_valid;
    end
    if (rx_valid && rx_ready) begin
      in_byte <= rx_byte;
      in_now  <= now_ms;
    end
  end

  // Frame state and latest measurement.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      running_sum        <= '0;
      header_good        <= 1'b1;
      latest_distance    <= '0;
      latest_amplitude   <= '0;
      latest_temperature <= '0;
      latest_stamp       <= '0;
    end else if (advance) begin
      if (byte_position == '0) begin
        running_sum   <= in_byte;
        header_good   <= (in_byte == lfcp_pkg::SyncByte);
        byte_position <= lfcp_pkg::PosWidth'(1);
      end else if (!is_last) begin
        running_sum   <= running_sum + in_byte;
        if (byte_position == lfcp_pkg::PosWidth'(1)) begin
          header_good <= header_good && (in_byte == lfcp_pkg::SyncByte);
        end
        byte_position <= byte_position + lfcp_pkg::PosWidth'(1);
      end else begin
        if (status_next == lfcp_pkg::STATUS_GOOD) begin
          latest_distance    <= {payload_bytes[1], payload_bytes[0]};
          latest_amplitude   <= {payload_bytes[3], payload_bytes[2]};
          latest_temperature <= {1'b0, raw_temp} - lfcp_pkg::TempOffset;
          latest_stamp       <= in_now;
        end
        byte_position <= '0;
        running_sum   <= '0;
        header_good   <= 1'b1;
      end
    end
  end

  // Payload store for bytes two through seven; written before it is read.
  always_ff @(posedge clk) begin
    if (advance && !is_last && (byte_position > lfcp_pkg::PosWidth'(1))) begin
      payload_bytes[store_idx] <= in_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance && is_last) begin
      res_vld <= 1'b1;
    end else if (frame_ready) begin
      res_vld <= 1'b0;
    end
    if (advance && is_last) begin
      res_status <= status_next;
    end
  end

  // The latest values change only when a result is loaded, which needs a
  // free output register, so they can drive the result fields directly.
  assign frame_valid         = res_vld;
  assign frame_status        = res_status;
  assign distance            = latest_distance;
  assign amplitude           = latest_amplitude;
  assign temperature_eighths = latest_temperature;
  assign stamp_ms            = latest_stamp;

  // Assertions.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= lfcp_pkg::LastPos)
    else $error("byte position left the frame");

  a_good_stamp: assert property (@(posedge clk) disable iff (rst)
    (advance && is_last && status_next == lfcp_pkg::STATUS_GOOD)
      |=> (stamp_ms == $past(in_now)))
    else $error("good frame did not latch its timestamp");

  a_bad_keeps: assert property (@(posedge clk) disable iff (rst)
    (advance && is_last && status_next != lfcp_pkg::STATUS_GOOD)
      |=> ($stable(distance) && $stable(stamp_ms) && $stable(temperature_eighths)))
    else $error("bad frame changed the latest measurement");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_vld && !frame_ready) |-> !(advance && is_last))
    else $error("result overwritten before it was taken");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && is_last) |=> (byte_position == '0 && header_good))
    else $error("frame state not restarted after final byte");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser regression bench
// Drives nine-byte measurement frames into the checksum parser and checks
// every frame report against a cycle-free prediction of the parser.
// ----------------------------------------------------------------------------
// A short directed part comes first. It sends a frame with a bad sync byte
// before any good frame has been seen, so the report must carry zeros. It
// then sends a good frame with an all-ones payload and the largest tick, and
// a frame whose checksum is wrong. Random frames follow. Most are well
// formed, with payloads biased toward all-zero and all-ones bytes so that
// both temperature extremes come up. The rest have a corrupted sync byte, a
// corrupted checksum or are pure noise.
//
// The sender offers words in bursts of random length separated by random
// gaps. The receiver cycles through several ready patterns. Once, it holds
// off for a long stretch so that the parser fills up and stalls its input.
// Inputs change on the falling edge and handshakes are sampled on the
// rising edge, so no check depends on event order within a time step.
module tb_top;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned RandomFrames  = 58;
  localparam int unsigned HoldOffAfter  = 200;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned MaxReports    = 10;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SYNC,
    FRAME_BAD_SUM,
    FRAME_NOISE
  } frame_kind_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_SPARSE,
    RDY_CYCLIC
  } ready_mode_t;

  // One word on the byte channel.
  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] tick;
  } rx_word_t;

  // One word on the result channel.
  typedef struct packed {
    lfcp_pkg::frame_status_t        status;
    logic [15:0]                    distance;
    logic [15:0]                    amplitude;
    logic [lfcp_pkg::TempWidth-1:0] temperature;
    logic [31:0]                    stamp;
  } frame_report_t;

  typedef logic [lfcp_pkg::FrameLen-1:0][7:0] frame_bytes_t;

  // Every input has a known value from time zero.
  logic                                  clk         = 1'b0;
  logic                                  rst         = 1'b1;
  logic                                  rx_valid    = 1'b0;
  logic                                  rx_ready;
  logic [7:0]                            rx_byte     = '0;
  logic [31:0]                           now_ms      = '0;
  logic                                  frame_valid;
  logic                                  frame_ready = 1'b0;
  logic [1:0]                            frame_status;
  logic [15:0]                           distance;
  logic [15:0]                           amplitude;
  logic signed [lfcp_pkg::TempWidth-1:0] temperature_eighths;
  logic [31:0]                           stamp_ms;

  lidar_frame_checksum_parser DUT (
    .clk                 (clk),
    .rst                 (rst),
    .rx_valid            (rx_valid),
    .rx_ready            (rx_ready),
    .rx_byte             (rx_byte),
    .now_ms              (now_ms),
    .frame_valid         (frame_valid),
    .frame_ready         (frame_ready),
    .frame_status        (frame_status),
    .distance            (distance),
    .amplitude           (amplitude),
    .temperature_eighths (temperature_eighths),
    .stamp_ms            (stamp_ms)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Predicted parser state. The payload store holds frame bytes 2 to 7.
  int                             frame_pos      = 0;
  logic [7:0]                     sum_acc        = '0;
  logic                           sync_ok        = 1'b1;
  logic [7:0]                     payload_store [lfcp_pkg::PayloadLen];
  logic [15:0]                    held_distance  = '0;
  logic [15:0]                    held_amplitude = '0;
  logic [lfcp_pkg::TempWidth-1:0] held_temp      = '0;
  logic [31:0]                    held_stamp     = '0;

  rx_word_t      rx_words_pending [$];
  frame_report_t frame_reports_due [$];

  // Words taken by the parser, counted by the checker, and words put on
  // the channel, counted by the driver. They differ while a word waits.
  int unsigned rx_taken    = 0;
  int unsigned rx_offered  = 0;
  int unsigned fault_count = 0;

  // Folds one accepted byte into the predicted state. The ninth byte of a
  // frame judges it and queues the report that the parser must send.
  task automatic fold_rx_byte(input logic [7:0] data, input logic [31:0] tick);
    frame_report_t rep;
    logic [15:0]   raw_temp;
    if (frame_pos == 0) begin
      sum_acc   = data;
      sync_ok   = (data == lfcp_pkg::SyncByte);
      frame_pos = 1;
    end else if (frame_pos < int'(lfcp_pkg::LastPos)) begin
      sum_acc = sum_acc + data;
      if (frame_pos == 1) begin
        sync_ok = sync_ok && (data == lfcp_pkg::SyncByte);
      end else begin
        payload_store[frame_pos - 2] = data;
      end
      frame_pos = frame_pos + 1;
    end else begin
      // A bad sync byte wins over the checksum; only a good frame moves
      // the measurement forward.
      if (!sync_ok) begin
        rep.status = lfcp_pkg::STATUS_BAD_HEADER;
      end else if (sum_acc != data) begin
        rep.status = lfcp_pkg::STATUS_BAD_SUM;
      end else begin
        rep.status     = lfcp_pkg::STATUS_GOOD;
        held_distance  = {payload_store[1], payload_store[0]};
        held_amplitude = {payload_store[3], payload_store[2]};
        raw_temp       = {payload_store[5], payload_store[4]};
        held_temp      = {1'b0, raw_temp} - lfcp_pkg::TempOffset;
        held_stamp     = tick;
      end
      rep.distance    = held_distance;
      rep.amplitude   = held_amplitude;
      rep.temperature = held_temp;
      rep.stamp       = held_stamp;
      frame_reports_due.push_back(rep);
      frame_pos = 0;
      sum_acc   = '0;
      sync_ok   = 1'b1;
    end
  endtask

  function automatic string show_report(input frame_report_t rep);
    return $sformatf("status=%0d distance=%0d amplitude=%0d temp=%0d stamp=%0d",
                     rep.status, rep.distance, rep.amplitude,
                     $signed(rep.temperature), rep.stamp);
  endfunction

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= MaxReports) $display("%s", msg);
  endfunction

  // Stimulus helpers. Bytes and ticks lean toward their extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_tick();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Low eight bits of the sum of bytes 0 to 7.
  function automatic logic [7:0] sum8(input frame_bytes_t body);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < lfcp_pkg::FrameLen - 1; i++) acc = acc + body[i];
    return acc;
  endfunction

  // Queues the nine words of one frame. The tick matters only on the last
  // byte, but every byte carries one so that all tick bits toggle.
  task automatic queue_frame(input frame_bytes_t body, input logic [31:0] last_tick);
    rx_word_t word;
    for (int i = 0; i < lfcp_pkg::FrameLen; i++) begin
      word.data = body[i];
      word.tick = (i == lfcp_pkg::FrameLen - 1) ? last_tick : pick_tick();
      rx_words_pending.push_back(word);
    end
  endtask

  task automatic make_frame(input frame_kind_t kind);
    frame_bytes_t body;
    int           style;
    style   = $urandom_range(0, 9);
    body[0] = lfcp_pkg::SyncByte;
    body[1] = lfcp_pkg::SyncByte;
    for (int i = 2; i < lfcp_pkg::FrameLen - 1; i++) begin
      body[i] = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : pick_byte();
    end
    case (kind)
      FRAME_BAD_SYNC: begin
        // Spoil the first, the second or both sync bytes. The checksum is
        // right half of the time; it must be ignored either way.
        case ($urandom_range(0, 2))
          0: body[0] ^= 8'($urandom_range(1, 255));
          1: body[1] ^= 8'($urandom_range(1, 255));
          default: begin
            body[0] ^= 8'($urandom_range(1, 255));
            body[1] ^= 8'($urandom_range(1, 255));
          end
        endcase
        body[8] = $urandom_range(0, 1) ? sum8(body) : 8'($urandom);
      end
      FRAME_BAD_SUM: body[8] = sum8(body) ^ 8'($urandom_range(1, 255));
      FRAME_NOISE: begin
        for (int i = 0; i < lfcp_pkg::FrameLen; i++) body[i] = 8'($urandom);
      end
      default: body[8] = sum8(body);
    endcase
    queue_frame(body, pick_tick());
  endtask

  // Sender: bursts of random length with random gaps between them, and now
  // and then a long burst with no gap at all. A word stays on the channel,
  // unchanged, until the checker has seen it taken.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : rx_driver
    rx_word_t word;
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (rx_taken != rx_offered) begin
      // The current word has not been taken yet.
    end else if (gap_left != 0) begin
      rx_valid <= 1'b0;
      gap_left--;
    end else if (rx_words_pending.size() != 0) begin
      word = rx_words_pending.pop_front();
      rx_valid <= 1'b1;
      rx_byte  <= word.data;
      now_ms   <= word.tick;
      rx_offered++;
      if (burst_left != 0) begin
        burst_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(60, 150);
        gap_left   = 0;
      end else begin
        burst_left = $urandom_range(0, 23);
        gap_left   = $urandom_range(1, 12);
      end
    end else begin
      rx_valid <= 1'b0;
    end
  end

  // Receiver: a ready pattern that changes at random intervals. Once
  // enough bytes have gone in, it refuses reports for a long stretch while
  // the sender keeps offering, which backs the parser up into its input.
  int unsigned hold_left   = 0;
  int unsigned mode_left   = 0;
  int unsigned ready_phase = 0;
  logic        hold_done   = 1'b0;
  ready_mode_t ready_mode  = RDY_ALWAYS;

  always @(negedge clk) begin : frame_receiver
    if (rst) begin
      frame_ready <= 1'b0;
    end else if (hold_left != 0) begin
      frame_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && rx_taken >= HoldOffAfter) begin
      hold_done = 1'b1;
      hold_left = HoldOffCycles - 1;
      frame_ready <= 1'b0;
    end else begin
      ready_phase++;
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        RDY_ALWAYS: frame_ready <= 1'b1;
        RDY_HALF:   frame_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: frame_ready <= ($urandom_range(0, 7) == 0);
        default:    frame_ready <= (ready_phase % 4 != 0);
      endcase
    end
  end

  // Checker. A report taken at this edge came from bytes taken at earlier
  // edges, so it is compared before this edge's byte is folded in.
  always @(posedge clk) begin : report_checker
    frame_report_t seen;
    frame_report_t due;
    if (!rst) begin
      if (frame_valid && frame_ready) begin
        seen.status      = lfcp_pkg::frame_status_t'(frame_status);
        seen.distance    = distance;
        seen.amplitude   = amplitude;
        seen.temperature = temperature_eighths;
        seen.stamp       = stamp_ms;
        if (frame_reports_due.size() == 0) begin
          log_fault({"unexpected frame report: ", show_report(seen)});
        end else begin
          due = frame_reports_due.pop_front();
          if (seen.status !== due.status || seen.distance !== due.distance ||
              seen.amplitude !== due.amplitude ||
              seen.temperature !== due.temperature || seen.stamp !== due.stamp) begin
            log_fault($sformatf("frame report mismatch: expected %s, got %s",
                                show_report(due), show_report(seen)));
          end
        end
      end
      if (rx_valid && rx_ready) begin
        fold_rx_byte(rx_byte, now_ms);
        rx_taken++;
      end
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  // The longest correct quiet spell is the receiver's hold-off.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (rx_valid && rx_ready) || (frame_valid && frame_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles == StallLimit) begin
      $display("no word moved for %0d cycles, %0d frame reports outstanding",
               StallLimit, frame_reports_due.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stimulus
    frame_bytes_t body;
    int           pick;

    // Bad first sync byte before any good frame: the report carries zeros.
    body[0] = 8'h00;
    body[1] = lfcp_pkg::SyncByte;
    for (int i = 2; i < lfcp_pkg::FrameLen - 1; i++) body[i] = 8'hA5;
    body[8] = sum8(body);
    queue_frame(body, 32'h0000_1234);

    // Good frame with every payload byte at all ones and the largest tick.
    body[0] = lfcp_pkg::SyncByte;
    for (int i = 2; i < lfcp_pkg::FrameLen - 1; i++) body[i] = 8'hFF;
    body[8] = sum8(body);
    queue_frame(body, 32'hFFFF_FFFF);

    // Good sync bytes, wrong checksum: the all-ones values must stay.
    for (int i = 2; i < lfcp_pkg::FrameLen - 1; i++) body[i] = 8'h00;
    body[8] = sum8(body) ^ 8'h80;
    queue_frame(body, 32'h0000_0000);

    for (int n = 0; n < RandomFrames; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      make_frame(FRAME_GOOD);
      else if (pick < 80) make_frame(FRAME_BAD_SYNC);
      else if (pick < 90) make_frame(FRAME_BAD_SUM);
      else                make_frame(FRAME_NOISE);
    end

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every word is taken and every report has come back, then
    // run on for a drain period so that any stray report shows.
    while (rx_words_pending.size() != 0 || rx_taken != rx_offered) @(posedge clk);
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
